// ===== hdl/hic_pkg.sv =====
// ----------------------------------------------------------------------------
// hic_pkg
// Shared types and constants for the magnetometer hard-iron calibrator.
// ----------------------------------------------------------------------------
package hic_pkg;

  localparam int AXIS_W     = 16;
  localparam int CORR_W     = AXIS_W + 1;
  localparam int TEMP_W     = 8;
  localparam int TEMP_OUT_W = TEMP_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM      = 1'd1;

  localparam logic [AXIS_W-1:0] SPAN_THRESHOLD_RST = 16'd740;
  localparam logic [TEMP_W-1:0] TEMP_TRIM_RST      = 8'd26;

  // per-axis tracker control
  typedef struct packed {
    logic update;  // widen min/max and recompute center
    logic seed;    // load min/max/center from the sample
  } axis_ctl_t;

endpackage

// ===== hdl/hic_axis.sv =====
// ----------------------------------------------------------------------------
// hic_axis
// One axis: min/max/center tracking, span test and offset correction.
// ----------------------------------------------------------------------------
module hic_axis (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hic_pkg::axis_ctl_t                    ctl,
  input  logic signed [hic_pkg::AXIS_W-1:0]     sample,
  input  logic        [hic_pkg::AXIS_W-1:0]     span_threshold,
  output logic signed [hic_pkg::CORR_W-1:0]     corrected,
  output logic                                  wide
);

  logic signed [hic_pkg::AXIS_W-1:0] min_r, min_nxt;
  logic signed [hic_pkg::AXIS_W-1:0] max_r, max_nxt;
  logic signed [hic_pkg::AXIS_W-1:0] center_r, center_nxt;
  logic signed [hic_pkg::CORR_W-1:0] sum;
  logic signed [hic_pkg::CORR_W-1:0] sum_adj;
  logic        [hic_pkg::CORR_W-1:0] span;

  always_comb begin
    if (ctl.seed) begin
      min_nxt = sample;
      max_nxt = sample;
    end else begin
      min_nxt = (sample < min_r) ? sample : min_r;
      max_nxt = (sample > max_r) ? sample : max_r;
    end
    sum = {min_nxt[hic_pkg::AXIS_W-1], min_nxt} + {max_nxt[hic_pkg::AXIS_W-1], max_nxt};
    // truncate toward zero: bias odd negatives up before the shift
    sum_adj = sum + {{(hic_pkg::CORR_W-1){1'b0}}, sum[hic_pkg::CORR_W-1]};
    center_nxt = sum_adj[hic_pkg::CORR_W-1:1];
    span = {max_nxt[hic_pkg::AXIS_W-1], max_nxt} - {min_nxt[hic_pkg::AXIS_W-1], min_nxt};
    wide = span > {1'b0, span_threshold};
    corrected = {sample[hic_pkg::AXIS_W-1], sample}
              - {center_r[hic_pkg::AXIS_W-1], center_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      max_r    <= '0;
      center_r <= '0;
    end else if (ctl.update || ctl.seed) begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      center_r <= ctl.seed ? sample : center_nxt;
    end
  end

endmodule

// ===== hdl/magnetometer_hard_iron_calibrator_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator_core
// Min/max hard-iron offset calibration with temperature offset.
// ----------------------------------------------------------------------------
// Path: an accepted sample moves from the input register to the result register,
//   and out_stall can hold it in either one (input reg, result reg).
// Throughput: one sample per cycle while out_stall is low; in_stall rises only
//   when both registers are full and out_stall is high.
// Reset (rst_n low, synchronous): pipeline empty, calibrating, no sample seen,
//   min/max/center zero, registers at their default values.
module magnetometer_hard_iron_calibrator_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [hic_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hic_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [hic_pkg::AXIS_W-1:0]      in_axis_x,
  input  logic signed [hic_pkg::AXIS_W-1:0]      in_axis_y,
  input  logic signed [hic_pkg::AXIS_W-1:0]      in_axis_z,
  input  logic signed [hic_pkg::TEMP_W-1:0]      in_temperature_raw,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_is_calibrated,
  output logic signed [hic_pkg::CORR_W-1:0]      out_corrected_x,
  output logic signed [hic_pkg::CORR_W-1:0]      out_corrected_y,
  output logic signed [hic_pkg::CORR_W-1:0]      out_corrected_z,
  output logic signed [hic_pkg::TEMP_OUT_W-1:0]  out_temperature_out
);

  logic [hic_pkg::AXIS_W-1:0]         span_threshold_r;
  logic signed [hic_pkg::TEMP_W-1:0]  temp_trim_r;

  logic                               in_vld_r;
  logic signed [hic_pkg::AXIS_W-1:0]  x_r, y_r, z_r;
  logic signed [hic_pkg::TEMP_W-1:0]  temp_r;

  logic                               seeded_r;
  logic                               locked_r;
  logic                               out_vld_r;

  logic                               advance;
  logic                               in_load;
  hic_pkg::axis_ctl_t                 axis_ctl;
  logic signed [hic_pkg::CORR_W-1:0]  corr_x, corr_y, corr_z;
  logic                               wide_x, wide_y, wide_z;
  logic signed [hic_pkg::TEMP_OUT_W-1:0] temp_sum;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_load   = !in_vld_r || advance;
  assign out_valid = out_vld_r;

  always_comb begin
    axis_ctl.seed   = advance && !locked_r && !seeded_r;
    axis_ctl.update = advance && !locked_r && seeded_r;
    temp_sum = {temp_r[hic_pkg::TEMP_W-1], temp_r}
             + {temp_trim_r[hic_pkg::TEMP_W-1], temp_trim_r};
  end

  hic_axis u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctl(axis_ctl), .sample(x_r),
    .span_threshold(span_threshold_r), .corrected(corr_x), .wide(wide_x)
  );

  hic_axis u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctl(axis_ctl), .sample(y_r),
    .span_threshold(span_threshold_r), .corrected(corr_y), .wide(wide_y)
  );

  hic_axis u_axis_z (
    .clk(clk), .rst_n(rst_n), .ctl(axis_ctl), .sample(z_r),
    .span_threshold(span_threshold_r), .corrected(corr_z), .wide(wide_z)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_threshold_r <= hic_pkg::SPAN_THRESHOLD_RST;
      temp_trim_r      <= hic_pkg::TEMP_TRIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hic_pkg::REG_SPAN_THRESHOLD: span_threshold_r <= cfg_wdata;
        hic_pkg::REG_TEMP_TRIM:      temp_trim_r      <= cfg_wdata[hic_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      x_r    <= in_axis_x;
      y_r    <= in_axis_y;
      z_r    <= in_axis_z;
      temp_r <= in_temperature_raw;
    end
  end

  // calibration phase flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
      locked_r <= 1'b0;
    end else begin
      if (axis_ctl.seed) begin
        seeded_r <= 1'b1;
      end
      if (axis_ctl.update && wide_x && wide_y && wide_z) begin
        locked_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_is_calibrated <= locked_r;
      if (locked_r) begin
        out_corrected_x     <= corr_x;
        out_corrected_y     <= corr_y;
        out_corrected_z     <= corr_z;
        out_temperature_out <= temp_sum;
      end else begin
        out_corrected_x     <= '0;
        out_corrected_y     <= '0;
        out_corrected_z     <= '0;
        out_temperature_out <= '0;
      end
    end
  end

  a_calib_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_calibrated |->
      out_corrected_x == '0 && out_corrected_y == '0 &&
      out_corrected_z == '0 && out_temperature_out == '0)
    else $error("calibrating result carries nonzero fields");

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |=> locked_r)
    else $error("lock dropped without reset");

  a_lock_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |-> seeded_r)
    else $error("locked before any sample seeded");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result back-pressure");

endmodule
